// ===== sv/ssdtm_pkg.sv =====
// Shared types and constants for the SSD template match score unit.
// Depends on nothing; every other file of the block but ssdtm_mem imports it.
`timescale 1ns / 1ps
`default_nettype none

package ssdtm_pkg;

    // Item operation codes
    localparam logic [1:0] OP_WR_TMPL = 2'd0;
    localparam logic [1:0] OP_WR_IMG  = 2'd1;
    localparam logic [1:0] OP_SCORE   = 2'd2;

    // Configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_TMPL_H = 2'd0;
    localparam logic [1:0] REG_TMPL_W = 2'd1;
    localparam logic [1:0] REG_IMG_H  = 2'd2;
    localparam logic [1:0] REG_IMG_W  = 2'd3;

    localparam int PADDR_W = 4;
    localparam int SCORE_W = 28;
    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] pos_row;
        logic [7:0] pos_col;
        logic [7:0] pixel;
    } t_in_item;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               out_of_range;
    } t_out_item;

    typedef struct packed {
        logic [6:0] tmpl_h;
        logic [6:0] tmpl_w;
        logic [8:0] img_h;
        logic [8:0] img_w;
    } t_cfg;

    // Sequencer to datapath control
    typedef struct packed {
        logic clear;   // new window starts, zero the sum
        logic sample;  // read data of both stores is valid this cycle
        logic last;    // this sample closes the window
    } t_acc_ctl;

endpackage

`default_nettype wire

// ===== sv/ssdtm_mem.sv =====
// Synchronous pixel store: one write port, one read port, registered read data.
// Depends on nothing; instanced twice by the top level (template and image).
`timescale 1ns / 1ps
`default_nettype none

module ssdtm_mem #(
    parameter int AW = 12,
    parameter int DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    localparam int DEPTH = 1 << AW;

    logic [DW-1:0] r_mem [0:DEPTH-1];
    logic [DW-1:0] r_rdata;

    // Write port; writes and scans never overlap, so no forwarding is needed
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sv/ssdtm_cfg.sv =====
// APB-style configuration registers with saturation of each dimension.
// Depends on ssdtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssdtm_cfg #(
    parameter int TMPL_MAX_ROWS = 64,
    parameter int TMPL_MAX_COLS = 64,
    parameter int IMG_MAX_ROWS  = 256,
    parameter int IMG_MAX_COLS  = 256
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ssdtm_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                  pwdata,
    output logic      [31:0]                  prdata,
    output logic                              pready,
    output ssdtm_pkg::t_cfg                   o_cfg
);

    import ssdtm_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [1:0] w_idx;
    logic [6:0] w_tmpl_h;
    logic [6:0] w_tmpl_w;
    logic [8:0] w_img_h;
    logic [8:0] w_img_w;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[3:2];

    // Saturate written values into 1..max
    always_comb begin
        w_tmpl_h = (32'(pwdata[6:0]) > TMPL_MAX_ROWS) ? 7'(TMPL_MAX_ROWS) : pwdata[6:0];
        w_tmpl_w = (32'(pwdata[6:0]) > TMPL_MAX_COLS) ? 7'(TMPL_MAX_COLS) : pwdata[6:0];
        w_img_h  = (32'(pwdata[8:0]) > IMG_MAX_ROWS)  ? 9'(IMG_MAX_ROWS)  : pwdata[8:0];
        w_img_w  = (32'(pwdata[8:0]) > IMG_MAX_COLS)  ? 9'(IMG_MAX_COLS)  : pwdata[8:0];
        if (w_tmpl_h == 7'd0) w_tmpl_h = 7'd1;
        if (w_tmpl_w == 7'd0) w_tmpl_w = 7'd1;
        if (w_img_h == 9'd0)  w_img_h  = 9'd1;
        if (w_img_w == 9'd0)  w_img_w  = 9'd1;
    end

    // Register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tmpl_h <= 7'd1;
            r_cfg.tmpl_w <= 7'd1;
            r_cfg.img_h  <= 9'd1;
            r_cfg.img_w  <= 9'd1;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_TMPL_H: r_cfg.tmpl_h <= w_tmpl_h;
                REG_TMPL_W: r_cfg.tmpl_w <= w_tmpl_w;
                REG_IMG_H:  r_cfg.img_h  <= w_img_h;
                REG_IMG_W:  r_cfg.img_w  <= w_img_w;
                default: ;
            endcase
        end
    end

    // Register read
    always_comb begin
        unique case (w_idx)
            REG_TMPL_H: prdata = 32'(r_cfg.tmpl_h);
            REG_TMPL_W: prdata = 32'(r_cfg.tmpl_w);
            REG_IMG_H:  prdata = 32'(r_cfg.img_h);
            REG_IMG_W:  prdata = 32'(r_cfg.img_w);
            default:    prdata = 32'd0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== sv/ssdtm_seq.sv =====
// Window scan sequencer: walks template rows and columns, one read of each store
// per cycle, and tags the returning read data for the datapath. Depends on ssdtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssdtm_seq #(
    parameter int TRB = 6,
    parameter int TCB = 6,
    parameter int IRB = 8,
    parameter int ICB = 8
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic [7:0]         i_row0,
    input  wire logic [7:0]         i_col0,
    input  ssdtm_pkg::t_cfg         i_cfg,
    output logic                    o_re,
    output logic [TRB+TCB-1:0]      o_tmpl_addr,
    output logic [IRB+ICB-1:0]      o_img_addr,
    output ssdtm_pkg::t_acc_ctl     o_ctl
);

    import ssdtm_pkg::*;

    logic       r_busy;
    logic [6:0] r_x;
    logic [6:0] r_y;
    logic [7:0] r_row0;
    logic [7:0] r_col0;
    logic       r_rd_valid;
    logic       r_rd_last;
    logic       w_row_end;
    logic       w_last;
    logic [8:0] w_img_row;
    logic [8:0] w_img_col;

    assign w_row_end = (r_y == i_cfg.tmpl_w - 7'd1);
    assign w_last    = w_row_end && (r_x == i_cfg.tmpl_h - 7'd1);

    // Advance the window position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && w_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x    <= 7'd0;
            r_y    <= 7'd0;
            r_row0 <= i_row0;
            r_col0 <= i_col0;
        end else if (r_busy) begin
            if (w_row_end) begin
                r_y <= 7'd0;
                r_x <= r_x + 7'd1;
            end else begin
                r_y <= r_y + 7'd1;
            end
        end
    end

    // Tag the read data as it comes back from the registered read port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
            r_rd_last  <= 1'b0;
        end else begin
            r_rd_valid <= r_busy;
            r_rd_last  <= r_busy && w_last;
        end
    end

    // Store addresses; an in-range window keeps image indexes below the store size
    assign w_img_row   = 9'(r_row0) + 9'(r_x);
    assign w_img_col   = 9'(r_col0) + 9'(r_y);
    assign o_re        = r_busy;
    assign o_tmpl_addr = {TRB'(r_x), TCB'(r_y)};
    assign o_img_addr  = {IRB'(w_img_row), ICB'(w_img_col)};

    assign o_ctl.clear  = i_start;
    assign o_ctl.sample = r_rd_valid;
    assign o_ctl.last   = r_rd_last;

endmodule

`default_nettype wire

// ===== sv/ssdtm_acc.sv =====
// Difference, square and saturating accumulate of one pixel pair per cycle.
// Depends on ssdtm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ssdtm_acc (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  ssdtm_pkg::t_acc_ctl              i_ctl,
    input  wire logic [7:0]                  i_img_px,
    input  wire logic [7:0]                  i_tmpl_px,
    output logic                             o_done,
    output logic [ssdtm_pkg::SCORE_W-1:0]    o_sum
);

    import ssdtm_pkg::*;

    logic [7:0]         w_diff;
    logic [15:0]        r_sq;
    logic               r_sq_valid;
    logic               r_sq_last;
    logic [SCORE_W:0]   n_sum;
    logic [SCORE_W-1:0] r_sum;
    logic               r_done;

    // Absolute difference
    assign w_diff = (i_img_px > i_tmpl_px) ? (i_img_px - i_tmpl_px)
                                           : (i_tmpl_px - i_img_px);

    // Square stage
    always_ff @(posedge i_clk) begin
        r_sq <= 16'(w_diff) * 16'(w_diff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_valid <= 1'b0;
            r_sq_last  <= 1'b0;
        end else begin
            r_sq_valid <= i_ctl.sample;
            r_sq_last  <= i_ctl.sample && i_ctl.last;
        end
    end

    // Accumulate, holding at the top value once it is reached
    assign n_sum = {1'b0, r_sum} + (SCORE_W + 1)'(r_sq);

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_sum <= '0;
        end else if (r_sq_valid) begin
            r_sum <= n_sum[SCORE_W] ? SCORE_MAX : n_sum[SCORE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_sq_valid && r_sq_last;
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_sum;

endmodule

`default_nettype wire

// ===== sv/ssd_template_match_score_unit.sv =====
// Sum-of-squared-differences template matcher. Pixel write items load one 8-bit
// pixel into the template or image store (writes beyond the store are dropped);
// a score item walks the template area one pixel pair per cycle through one read
// port of each store and returns the exact sum, saturated at 28 bits. A window
// that leaves the image returns zero with out_of_range set. One item is in
// flight at a time, but a new item is taken while the previous result waits in
// the output register. Dimension registers are to be written over the APB port
// only while the block is idle; the block itself does not enforce this. Values
// saturate into range.
// Depends on ssdtm_pkg, ssdtm_cfg, ssdtm_mem, ssdtm_seq and ssdtm_acc.
`timescale 1ns / 1ps
`default_nettype none

module ssd_template_match_score_unit #(
    parameter int TMPL_MAX_ROWS = 64,
    parameter int TMPL_MAX_COLS = 64,
    parameter int IMG_MAX_ROWS  = 256,
    parameter int IMG_MAX_COLS  = 256
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  ssdtm_pkg::t_in_item                i_item,
    output logic                               o_stall,
    output logic                               o_valid,
    output ssdtm_pkg::t_out_item               o_item,
    input  wire logic                          i_stall,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ssdtm_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);

    import ssdtm_pkg::*;

    localparam int TRB = (TMPL_MAX_ROWS > 1) ? $clog2(TMPL_MAX_ROWS) : 1;
    localparam int TCB = (TMPL_MAX_COLS > 1) ? $clog2(TMPL_MAX_COLS) : 1;
    localparam int IRB = (IMG_MAX_ROWS > 1)  ? $clog2(IMG_MAX_ROWS)  : 1;
    localparam int ICB = (IMG_MAX_COLS > 1)  ? $clog2(IMG_MAX_COLS)  : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    t_cfg               w_cfg;
    logic [1:0]         r_state;
    logic               w_accept;
    logic               w_oor;
    logic               w_start;
    logic               w_tmpl_we;
    logic               w_img_we;
    logic               w_re;
    logic [TRB+TCB-1:0] w_tmpl_raddr;
    logic [IRB+ICB-1:0] w_img_raddr;
    logic [7:0]         w_tmpl_px;
    logic [7:0]         w_img_px;
    t_acc_ctl           w_ctl;
    logic               w_done;
    logic [SCORE_W-1:0] w_sum;
    t_out_item          r_res;
    logic               r_out_valid;
    t_out_item          r_out;
    logic               w_out_free;

    ssdtm_cfg #(
        .TMPL_MAX_ROWS (TMPL_MAX_ROWS),
        .TMPL_MAX_COLS (TMPL_MAX_COLS),
        .IMG_MAX_ROWS  (IMG_MAX_ROWS),
        .IMG_MAX_COLS  (IMG_MAX_COLS)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Input transfer and decode
    assign o_stall  = (r_state != ST_IDLE);
    assign w_accept = i_valid && !o_stall;
    assign w_oor    = (9'(i_item.pos_row) + 9'(w_cfg.tmpl_h) > w_cfg.img_h) ||
                      (9'(i_item.pos_col) + 9'(w_cfg.tmpl_w) > w_cfg.img_w);
    assign w_start  = w_accept && (i_item.op == OP_SCORE) && !w_oor;

    assign w_tmpl_we = w_accept && (i_item.op == OP_WR_TMPL) &&
                       (32'(i_item.pos_row) < TMPL_MAX_ROWS) &&
                       (32'(i_item.pos_col) < TMPL_MAX_COLS);
    assign w_img_we  = w_accept && (i_item.op == OP_WR_IMG) &&
                       (32'(i_item.pos_row) < IMG_MAX_ROWS) &&
                       (32'(i_item.pos_col) < IMG_MAX_COLS);

    ssdtm_mem #(.AW(TRB + TCB), .DW(8)) u_tmpl_mem (
        .i_clk   (i_clk),
        .i_we    (w_tmpl_we),
        .i_waddr ({TRB'(i_item.pos_row), TCB'(i_item.pos_col)}),
        .i_wdata (i_item.pixel),
        .i_re    (w_re),
        .i_raddr (w_tmpl_raddr),
        .o_rdata (w_tmpl_px)
    );

    ssdtm_mem #(.AW(IRB + ICB), .DW(8)) u_img_mem (
        .i_clk   (i_clk),
        .i_we    (w_img_we),
        .i_waddr ({IRB'(i_item.pos_row), ICB'(i_item.pos_col)}),
        .i_wdata (i_item.pixel),
        .i_re    (w_re),
        .i_raddr (w_img_raddr),
        .o_rdata (w_img_px)
    );

    ssdtm_seq #(.TRB(TRB), .TCB(TCB), .IRB(IRB), .ICB(ICB)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_row0      (i_item.pos_row),
        .i_col0      (i_item.pos_col),
        .i_cfg       (w_cfg),
        .o_re        (w_re),
        .o_tmpl_addr (w_tmpl_raddr),
        .o_img_addr  (w_img_raddr),
        .o_ctl       (w_ctl)
    );

    ssdtm_acc u_acc (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_ctl),
        .i_img_px  (w_img_px),
        .i_tmpl_px (w_tmpl_px),
        .o_done    (w_done),
        .o_sum     (w_sum)
    );

    assign w_out_free = !r_out_valid || !i_stall;

    // Item control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept && (i_item.op == OP_SCORE)) begin
                        r_state <= w_oor ? ST_DONE : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (w_done) r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (w_out_free) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Hold the finished result until the output register is free
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && w_accept) begin
            r_res.score        <= '0;
            r_res.out_of_range <= 1'b1;
        end else if (r_state == ST_SCAN && w_done) begin
            r_res.score        <= w_sum;
            r_res.out_of_range <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && w_out_free) begin
            r_out <= r_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the SSD template match score unit: pixel loads, window
// scores and dimension settings, checked against an in-bench shadow of both stores.
// Depends on ssdtm_pkg and ssd_template_match_score_unit.
`timescale 1ns / 1ps

module testbench;
    import ssdtm_pkg::*;

    localparam int TMPL_ROWS   = 64;
    localparam int TMPL_COLS   = 64;
    localparam int IMG_ROWS    = 256;
    localparam int IMG_COLS    = 256;
    localparam int IDLE_PCT    = 31;
    localparam int RX_HOLD_CYC = 400;
    localparam int DRAIN_LIMIT = 500000;
    localparam longint RUN_LIMIT_NS = 64'd10_000_000;

    // Clock, reset and block inputs, all known from time zero
    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_valid = 1'b0;
    t_in_item            i_item  = '0;
    logic                i_stall = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [31:0]         pwdata  = '0;

    logic                o_stall;
    logic                o_valid;
    t_out_item           o_item;
    logic [31:0]         prdata;
    logic                pready;

    // Input items waiting for the driver, and scores waiting for the block
    t_in_item            pending_items [$];
    t_out_item           expected_scores [$];

    // Shadow of the block state, updated at acceptance
    logic [7:0]          shadow_tmpl [TMPL_ROWS*TMPL_COLS];
    logic [7:0]          shadow_img  [IMG_ROWS*IMG_COLS];
    int                  dim_th = 1;
    int                  dim_tw = 1;
    int                  dim_ih = 1;
    int                  dim_iw = 1;

    // Entries already loaded by queued items, so no score reads an unloaded pixel
    bit                  tmpl_loaded [TMPL_ROWS*TMPL_COLS];
    bit                  img_loaded  [IMG_ROWS*IMG_COLS];

    logic                in_taken      = 1'b0;
    bit                  quiet_on      = 1'b0;
    bit                  backlog_on    = 1'b0;
    int                  rx_hold_count = 0;

    int                  error_count    = 0;
    int                  items_accepted = 0;
    int                  scores_checked = 0;
    int                  oor_checked    = 0;
    int                  settings_count = 0;
    int                  readbacks      = 0;

    ssd_template_match_score_unit #(
        .TMPL_MAX_ROWS(TMPL_ROWS),
        .TMPL_MAX_COLS(TMPL_COLS),
        .IMG_MAX_ROWS (IMG_ROWS),
        .IMG_MAX_COLS (IMG_COLS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .i_item (i_item),
        .o_stall(o_stall),
        .o_valid(o_valid),
        .o_item (o_item),
        .i_stall(i_stall),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void note_error(input string msg);
        error_count++;
        if (error_count <= 10) begin
            $display("MISMATCH: %s", msg);
        end
    endfunction

    function automatic int clamp_dim(input int v, input int maxv);
        if (v < 1) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic bit window_fits(input int row, input int col);
        return (row + dim_th <= dim_ih) && (col + dim_tw <= dim_iw);
    endfunction

    function automatic int dim_value(input logic [1:0] idx);
        case (idx)
            REG_TMPL_H: return dim_th;
            REG_TMPL_W: return dim_tw;
            REG_IMG_H:  return dim_ih;
            default:    return dim_iw;
        endcase
    endfunction

    // Apply one accepted item to the shadow; queue the score it produces
    function automatic void shadow_apply(input t_in_item it);
        t_out_item       res;
        longint unsigned acc;
        int              row, col, a, b, d;
        row = int'(it.pos_row);
        col = int'(it.pos_col);
        case (it.op)
            OP_WR_TMPL: begin
                if (row < TMPL_ROWS && col < TMPL_COLS) begin
                    shadow_tmpl[row*TMPL_COLS + col] = it.pixel;
                end
            end
            OP_WR_IMG: begin
                if (row < IMG_ROWS && col < IMG_COLS) begin
                    shadow_img[row*IMG_COLS + col] = it.pixel;
                end
            end
            OP_SCORE: begin
                if (!window_fits(row, col)) begin
                    res.score        = '0;
                    res.out_of_range = 1'b1;
                end else begin
                    acc = 0;
                    for (int y = 0; y < dim_th; y++) begin
                        for (int x = 0; x < dim_tw; x++) begin
                            a = int'(shadow_img[(row + y)*IMG_COLS + col + x]);
                            b = int'(shadow_tmpl[y*TMPL_COLS + x]);
                            d = a - b;
                            acc += longint'(d * d);
                        end
                    end
                    res.score        = (acc > SCORE_MAX) ? SCORE_MAX : acc[SCORE_W-1:0];
                    res.out_of_range = 1'b0;
                end
                expected_scores.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // Driver: offer the next pending input item, hold the payload while stalled
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_taken) begin
            if (pending_items.size() != 0 && (quiet_on || $urandom_range(99) >= IDLE_PCT)) begin
                i_valid <= 1'b1;
                i_item  <= pending_items.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls, one long hold-off during the backlog phase
    always @(negedge i_clk) begin
        if (backlog_on && rx_hold_count < RX_HOLD_CYC) begin
            i_stall       <= 1'b1;
            rx_hold_count <= rx_hold_count + 1;
        end else begin
            i_stall <= !quiet_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Monitor: check each result transfer, then predict from each input transfer
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= i_valid && !o_stall;
            if (o_valid && !i_stall) begin
                if (expected_scores.size() == 0) begin
                    note_error($sformatf("result with no pending score: score=%0d oor=%0b",
                                         o_item.score, o_item.out_of_range));
                end else begin
                    want = expected_scores.pop_front();
                    if (o_item.score != want.score) begin
                        note_error($sformatf("score %0d: expected %0d, got %0d",
                                             scores_checked, want.score, o_item.score));
                    end
                    if (o_item.out_of_range != want.out_of_range) begin
                        note_error($sformatf("out_of_range %0d: expected %0b, got %0b",
                                             scores_checked, want.out_of_range,
                                             o_item.out_of_range));
                    end
                    scores_checked++;
                    if (want.out_of_range) oor_checked++;
                end
            end
            if (i_valid && !o_stall) begin
                items_accepted++;
                shadow_apply(i_item);
            end
        end
    end

    // Stimulus helpers
    function automatic int pick_pixel();
        case ($urandom_range(7))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(255);
        endcase
    endfunction

    task automatic push_item(input logic [1:0] op, input int row, input int col,
                             input int pix);
        t_in_item it;
        it.op      = op;
        it.pos_row = 8'(row);
        it.pos_col = 8'(col);
        it.pixel   = 8'(pix);
        pending_items.push_back(it);
        if (op == OP_WR_TMPL && row < TMPL_ROWS && col < TMPL_COLS) begin
            tmpl_loaded[row*TMPL_COLS + col] = 1'b1;
        end
        if (op == OP_WR_IMG && row < IMG_ROWS && col < IMG_COLS) begin
            img_loaded[row*IMG_COLS + col] = 1'b1;
        end
    endtask

    // Load the template area and the image window at (row, col); a negative
    // pixel value means random content, only_new skips entries already loaded
    task automatic paint_window(input int row, input int col, input int tpix,
                                input int ipix, input bit only_new);
        for (int y = 0; y < dim_th; y++) begin
            for (int x = 0; x < dim_tw; x++) begin
                if (!only_new || !tmpl_loaded[y*TMPL_COLS + x]) begin
                    push_item(OP_WR_TMPL, y, x, (tpix < 0) ? pick_pixel() : tpix);
                end
                if (!only_new || !img_loaded[(row + y)*IMG_COLS + col + x]) begin
                    push_item(OP_WR_IMG, row + y, col + x, (ipix < 0) ? pick_pixel() : ipix);
                end
            end
        end
    endtask

    task automatic push_score(input int row, input int col);
        if (window_fits(row, col)) begin
            paint_window(row, col, -1, -1, 1'b1);
        end
        push_item(OP_SCORE, row, col, $urandom_range(255));
    endtask

    // Random traffic: mostly loaded-window scores, plus loads, misses and noise
    task automatic random_traffic(input int n);
        int counted, pick, row, col, row_lo, col_lo;
        counted = 0;
        while (counted < n) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                if (dim_ih >= dim_th && dim_iw >= dim_tw) begin
                    push_score($urandom_range(dim_ih - dim_th), $urandom_range(dim_iw - dim_tw));
                end else begin
                    push_score($urandom_range(255), $urandom_range(255));
                end
                counted++;
            end else if (pick < 62) begin
                row_lo = (dim_ih - dim_th + 1 < 0) ? 0 : dim_ih - dim_th + 1;
                col_lo = (dim_iw - dim_tw + 1 < 0) ? 0 : dim_iw - dim_tw + 1;
                if (row_lo <= 255 && (col_lo > 255 || $urandom_range(1) == 1)) begin
                    row = $urandom_range(255, row_lo);
                    col = $urandom_range(255);
                end else if (col_lo <= 255) begin
                    row = $urandom_range(255);
                    col = $urandom_range(255, col_lo);
                end else begin
                    row = $urandom_range(dim_ih - dim_th);
                    col = $urandom_range(dim_iw - dim_tw);
                end
                push_score(row, col);
                counted++;
            end else if (pick < 72) begin
                push_item(OP_WR_IMG, $urandom_range(255), $urandom_range(255), pick_pixel());
                counted++;
            end else if (pick < 80) begin
                row = $urandom_range(255);
                col = $urandom_range(255);
                push_item(OP_WR_TMPL, row, col, pick_pixel());
                if (row < TMPL_ROWS && col < TMPL_COLS) counted++;
            end else if (pick < 92) begin
                push_item(OP_WR_TMPL, $urandom_range(dim_th - 1), $urandom_range(dim_tw - 1),
                          pick_pixel());
                counted++;
            end else if (pick < 96) begin
                push_item(OP_WR_IMG, $urandom_range(dim_ih - 1), $urandom_range(dim_iw - 1),
                          pick_pixel());
                counted++;
            end else begin
                push_item(2'b11, $urandom_range(255), $urandom_range(255), $urandom_range(255));
            end
        end
    endtask

    // Wait until every transfer is taken and every score is back, then let
    // the datapath settle
    task automatic drain();
        int guard;
        guard = 0;
        while ((pending_items.size() != 0 || i_valid || expected_scores.size() != 0)
               && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (dim_th * dim_tw + 8) @(posedge i_clk);
    endtask

    task automatic apb_access(input bit wr, input logic [1:0] idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_dim_reg(input logic [1:0] idx);
        logic [31:0] rd;
        apb_access(1'b0, idx, 32'd0, rd);
        readbacks++;
        if (rd != 32'(dim_value(idx))) begin
            note_error($sformatf("register %0d readback: expected %0d, got %0d",
                                 idx, dim_value(idx), rd));
        end
    endtask

    // Write one dimension register, track its saturated value, read it back
    task automatic set_dim_reg(input logic [1:0] idx, input logic [31:0] raw);
        logic [31:0] rd;
        apb_access(1'b1, idx, raw, rd);
        case (idx)
            REG_TMPL_H: dim_th = clamp_dim(int'(raw & 32'h7F), TMPL_ROWS);
            REG_TMPL_W: dim_tw = clamp_dim(int'(raw & 32'h7F), TMPL_COLS);
            REG_IMG_H:  dim_ih = clamp_dim(int'(raw & 32'h1FF), IMG_ROWS);
            default:    dim_iw = clamp_dim(int'(raw & 32'h1FF), IMG_COLS);
        endcase
        check_dim_reg(idx);
    endtask

    task automatic set_dims(input logic [31:0] th, input logic [31:0] tw,
                            input logic [31:0] ih, input logic [31:0] iw);
        set_dim_reg(REG_TMPL_H, th);
        set_dim_reg(REG_TMPL_W, tw);
        set_dim_reg(REG_IMG_H, ih);
        set_dim_reg(REG_IMG_W, iw);
        settings_count++;
    endtask

    // Run limit
    initial begin
        #(RUN_LIMIT_NS);
        $display("DONE: errors detected");
        $finish;
    end

    // Main sequence
    initial begin : stimulus
        for (int k = 0; k < TMPL_ROWS*TMPL_COLS; k++) shadow_tmpl[k] = '0;
        for (int k = 0; k < IMG_ROWS*IMG_COLS; k++) shadow_img[k] = '0;

        // Hold reset, then release it
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values of all dimension registers
        check_dim_reg(REG_TMPL_H);
        check_dim_reg(REG_TMPL_W);
        check_dim_reg(REG_IMG_H);
        check_dim_reg(REG_IMG_W);

        // Directed: 1x1 template on 1x1 image, pixel extremes, misses,
        // dropped loads beyond the template store, unused op code
        push_item(OP_WR_TMPL, 0, 0, 0);
        push_item(OP_WR_IMG, 0, 0, 255);
        push_item(OP_SCORE, 0, 0, 0);
        push_item(OP_SCORE, 0, 1, 255);
        push_item(OP_SCORE, 1, 0, 0);
        push_item(OP_SCORE, 255, 255, 255);
        push_item(OP_WR_TMPL, 64, 0, 200);
        push_item(OP_WR_TMPL, 0, 64, 200);
        push_item(OP_WR_TMPL, 255, 255, 77);
        push_item(2'b11, 0, 0, 9);
        push_item(OP_SCORE, 0, 0, 0);
        push_item(OP_WR_IMG, 255, 255, 0);
        push_item(OP_WR_IMG, 0, 255, 170);
        push_item(OP_WR_TMPL, 63, 63, 255);
        push_item(OP_SCORE, 0, 0, 0);
        push_item(OP_WR_TMPL, 0, 0, 255);
        push_item(OP_SCORE, 0, 0, 0);
        push_item(OP_WR_IMG, 0, 0, 0);
        push_item(OP_SCORE, 0, 0, 0);
        drain();

        // Small template on a small image
        set_dims(32'd3, 32'd4, 32'd16, 32'd20);
        random_traffic(30);
        drain();

        // Zero writes saturate to the smallest size
        set_dims(32'd0, 32'd0, 32'd0, 32'd0);
        random_traffic(10);
        drain();

        // Largest sizes, oversized values saturate; full-scale score first
        set_dims(32'hFFFF_FFFF, 32'd64, 32'd511, 32'd300);
        paint_window(0, 0, 0, 255, 1'b0);
        push_item(OP_SCORE, 0, 0, 0);
        push_score(192, 192);
        push_score(100, 37);
        push_score(193, 0);
        push_score(0, 193);
        random_traffic(4);
        drain();

        // Long stretch with no idling on either side
        quiet_on = 1'b1;
        set_dims(32'd2, 32'd5, 32'd256, 32'd256);
        random_traffic(35);
        drain();
        quiet_on = 1'b0;

        // Receiver holds off while the sender keeps offering
        set_dims(32'd4, 32'd4, 32'd40, 32'd40);
        backlog_on = 1'b1;
        random_traffic(30);
        drain();
        backlog_on = 1'b0;

        // One-row and one-column templates, then template as large as image
        set_dims(32'd1, 32'd64, 32'd8, 32'd256);
        random_traffic(12);
        drain();
        set_dims(32'd64, 32'd1, 32'd256, 32'd8);
        random_traffic(12);
        drain();
        set_dims(32'd8, 32'd8, 32'd8, 32'd8);
        random_traffic(8);
        drain();

        // Anything still expected is lost
        if (expected_scores.size() != 0) begin
            note_error($sformatf("%0d scores never returned", expected_scores.size()));
        end

        $display("Run covered %0d transfers in, %0d scores checked (%0d out of range),",
                 items_accepted, scores_checked, oor_checked);
        $display("%0d dimension settings and %0d register readbacks; %0d errors.",
                 settings_count, readbacks, error_count);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ssdtm_pkg.sv
sv/ssdtm_mem.sv
sv/ssdtm_cfg.sv
sv/ssdtm_seq.sv
sv/ssdtm_acc.sv
sv/ssd_template_match_score_unit.sv
bench/testbench.sv
